>>> design/pcf_pkg.sv
// ----------------------------------------------------------------------------
// Pitch complementary filter package
// Constants and the arctangent table shared by the filter datapath.
// ----------------------------------------------------------------------------
package pcf_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GYRO_STEP_GAIN = 2'd0,
        CFG_BLEND_WEIGHT   = 2'd1,
        CFG_BIAS_GAIN      = 2'd2
    } cfg_index_t;

    localparam logic [31:0] GYRO_STEP_GAIN_RESET = 32'd327706;
    localparam logic [16:0] BLEND_WEIGHT_RESET   = 17'd63570;
    localparam logic [47:0] BIAS_GAIN_RESET      = 48'd2814750;
    localparam logic [16:0] BLEND_ONE            = 17'd65536;

    // Number of square root iterations for a 48-bit radicand.
    localparam int SQRT_STEPS = 24;

    // atan(2^-i) in degrees, Q16.16, rounded.
    localparam logic [22:0] ATAN_TABLE [32] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234378,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0,
        23'd0,       23'd0,       23'd0,      23'd0,
        23'd0,       23'd0,       23'd0,      23'd0
    };

endpackage

>>> design/pitch_complementary_filter.sv
// ----------------------------------------------------------------------------
// Pitch complementary filter
// Accelerometer pitch by square root and CORDIC, gyro integration, blending
// and gyro bias tracking, all in fixed point under one small sequencer.
// ----------------------------------------------------------------------------
// The input is stalled while a request is in flight, and the next request
// can be taken once the sequencer is back in idle. A request runs through a
// bit-serial square root and CORDIC vectoring, then three products through a
// single 32x32 multiplier, each built from four partial products and an
// accumulate, and eight set-up and fix-up steps. An all-zero accelerometer
// vector skips the CORDIC vectoring. A failed-read request goes straight to
// the finish step. A finished result sits in the output register, so a new
// request may be taken while the previous result still waits. A request that
// finishes while the output register is still held stays stalled until that
// result leaves. Angles are signed Q16.16 degrees, and the bias is signed
// Q16.32 gyro LSB.
// ----------------------------------------------------------------------------
module pitch_complementary_filter #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    // Sample channel.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_pitch,
    input  logic               read_failed,
    // Result channel.
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pitch_angle,
    output logic signed [47:0] bias_estimate,
    output logic               valid_res,
    // Configuration write channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import pcf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_CINIT,
        ST_CORDIC,
        ST_STEP_LOAD,
        ST_STEP_MUL,
        ST_STEP_FIN,
        ST_BLEND_MUL,
        ST_BLEND_FIN,
        ST_ANGLE,
        ST_ERR,
        ST_BIAS_MUL,
        ST_BIAS_FIN,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [5:0]         cnt_reg;
    logic               fail_reg;
    logic signed [31:0] angle_reg;
    logic signed [47:0] bias_reg;
    logic               out_valid_reg;
    logic signed [31:0] pitch_reg;
    logic signed [47:0] bias_out_reg;
    logic               valid_res_reg;

    logic [31:0] gyro_step_gain_reg;
    logic [16:0] blend_weight_reg;
    logic [47:0] bias_gain_reg;

    // Datapath registers.
    logic signed [15:0] ax_reg, ay_reg, az_reg, gy_reg;
    logic [47:0]        n_reg;
    logic [47:0]        res_reg;
    logic [46:0]        bit_reg;
    logic signed [27:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [49:0]        mul_a_reg;
    logic [47:0]        mul_b_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [1:0]         psh_reg;
    logic [83:0]        acc_reg;
    logic signed [55:0] mix_reg;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_step_gain_reg <= GYRO_STEP_GAIN_RESET;
            blend_weight_reg   <= BLEND_WEIGHT_RESET;
            bias_gain_reg      <= BIAS_GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GYRO_STEP_GAIN: gyro_step_gain_reg <= cfg_data[31:0];
                CFG_BLEND_WEIGHT:   blend_weight_reg   <= cfg_data[16:0];
                CFG_BIAS_GAIN:      bias_gain_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Combinational helpers for each sequencer step.
    // ------------------------------------------------------------------
    // Squared horizontal magnitude of the Y and Z axes.
    logic signed [31:0] ay_sq, az_sq;
    logic [32:0]        sq_sum;
    assign ay_sq  = ay_reg * ay_reg;
    assign az_sq  = az_reg * az_reg;
    assign sq_sum = {1'b0, ay_sq} + {1'b0, az_sq};

    // One restoring square root step.
    logic [48:0] sqrt_trial;
    logic        sqrt_ge;
    assign sqrt_trial = {1'b0, res_reg} + {2'b0, bit_reg};
    assign sqrt_ge    = {1'b0, n_reg} >= sqrt_trial;

    // One CORDIC vectoring step.
    logic signed [27:0] x_shift, y_shift;
    logic signed [31:0] atan_val;
    assign x_shift  = x_reg >>> cnt_reg[4:0];
    assign y_shift  = y_reg >>> cnt_reg[4:0];
    assign atan_val = $signed({9'b0, ATAN_TABLE[cnt_reg[4:0]]});

    // Shared multiplier: one 32x32 partial product per cycle.
    logic [31:0] a_chunk, b_chunk;
    logic [83:0] prod_aligned;
    assign a_chunk = cnt_reg[1] ? {14'b0, mul_a_reg[49:32]} : mul_a_reg[31:0];
    assign b_chunk = cnt_reg[0] ? {16'b0, mul_b_reg[47:32]} : mul_b_reg[31:0];

    always_comb
    begin
        case (psh_reg)
            2'd0:    prod_aligned = {20'b0, prod_reg};
            2'd1:    prod_aligned = 84'({prod_reg, 32'b0});
            default: prod_aligned = 84'({prod_reg, 64'b0});
        endcase
    end

    // Gyro difference against the bias, scaled to Q16.32.
    logic signed [49:0] diff;
    logic [49:0]        diff_mag;
    assign diff     = {{2{gy_reg[15]}}, gy_reg, 32'b0} - 50'(bias_reg);
    assign diff_mag = diff[49] ? 50'(-diff) : 50'(diff);

    // Rounded gyro step, predicted angle and its distance from the observation.
    logic [83:0]        step_rnd;
    logic signed [37:0] step_val, pred, pred_err;
    logic [37:0]        pred_err_mag;
    logic [16:0]        kappa;
    assign step_rnd     = acc_reg + (84'(1) << 47);
    assign step_val     = neg_reg ? -$signed({2'b0, step_rnd[83:48]})
                                  : $signed({2'b0, step_rnd[83:48]});
    assign pred         = 38'(angle_reg) + step_val;
    assign pred_err     = pred - 38'(z_reg);
    assign pred_err_mag = pred_err[37] ? 38'(-pred_err) : 38'(pred_err);
    assign kappa        = (blend_weight_reg > BLEND_ONE) ? BLEND_ONE : blend_weight_reg;

    // Blend: obs * 2^16 + kappa * (pred - obs).
    logic signed [55:0] obs_scaled, blend_prod, mix;
    assign obs_scaled = {{8{z_reg[31]}}, z_reg, 16'b0};
    assign blend_prod = $signed(acc_reg[55:0]);
    assign mix        = neg_reg ? obs_scaled - blend_prod : obs_scaled + blend_prod;

    // Round the blend to Q16.16 and saturate.
    logic [55:0]        mix_mag;
    logic [56:0]        mix_rnd;
    logic signed [41:0] angle_wide;
    logic signed [31:0] angle_sat;
    assign mix_mag    = mix_reg[55] ? 56'(-mix_reg) : 56'(mix_reg);
    assign mix_rnd    = {1'b0, mix_mag} + 57'(32768);
    assign angle_wide = mix_reg[55] ? -$signed({1'b0, mix_rnd[56:16]})
                                    : $signed({1'b0, mix_rnd[56:16]});

    always_comb
    begin
        if (angle_wide > 42'sd2147483647)
            angle_sat = 32'sh7fffffff;
        else if (angle_wide < -42'sd2147483648)
            angle_sat = 32'sh80000000;
        else
            angle_sat = angle_wide[31:0];
    end

    // Error of the new angle against the observation.
    logic signed [32:0] angle_err;
    logic [32:0]        angle_err_mag;
    assign angle_err     = 33'(angle_reg) - 33'(z_reg);
    assign angle_err_mag = angle_err[32] ? 33'(-angle_err) : 33'(angle_err);

    // Bias update with saturation to 48 bits.
    logic [83:0]        corr_rnd;
    logic signed [53:0] corr_val, bias_wide;
    logic signed [47:0] bias_sat;
    assign corr_rnd  = acc_reg + (84'(1) << 31);
    assign corr_val  = neg_reg ? -$signed({2'b0, corr_rnd[83:32]})
                               : $signed({2'b0, corr_rnd[83:32]});
    assign bias_wide = 54'(bias_reg) - corr_val;

    always_comb
    begin
        if (bias_wide > 54'sd140737488355327)
            bias_sat = 48'sh7fffffffffff;
        else if (bias_wide < -54'sd140737488355328)
            bias_sat = 48'sh800000000000;
        else
            bias_sat = bias_wide[47:0];
    end

    // ------------------------------------------------------------------
    // Sequencer, filter state and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fail_reg      <= 1'b0;
            angle_reg     <= '0;
            bias_reg      <= '0;
            out_valid_reg <= 1'b0;
            pitch_reg     <= '0;
            bias_out_reg  <= '0;
            valid_res_reg <= 1'b0;
        end
        else
        begin
            // A result leaving while the next one is loaded is handled in
            // the finish step.
            if (out_valid_reg && !out_stall && state_reg != ST_FINISH)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        fail_reg  <= read_failed;
                        state_reg <= read_failed ? ST_FINISH : ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (cnt_reg == 6'(SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_CINIT;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_CINIT:
                begin
                    cnt_reg <= '0;
                    // With no accelerometer vector the observed pitch stays zero.
                    if (res_reg[23:0] == 24'd0 && ax_reg == 16'sd0)
                        state_reg <= ST_STEP_LOAD;
                    else
                        state_reg <= ST_CORDIC;
                end
                ST_CORDIC:
                begin
                    if (cnt_reg == 6'(CORDIC_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_STEP_LOAD;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_STEP_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_STEP_MUL;
                end
                ST_STEP_MUL, ST_BLEND_MUL, ST_BIAS_MUL:
                begin
                    if (cnt_reg == 6'd4)
                    begin
                        cnt_reg <= '0;
                        case (state_reg)
                            ST_STEP_MUL:  state_reg <= ST_STEP_FIN;
                            ST_BLEND_MUL: state_reg <= ST_BLEND_FIN;
                            default:      state_reg <= ST_BIAS_FIN;
                        endcase
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_STEP_FIN:  state_reg <= ST_BLEND_MUL;
                ST_BLEND_FIN: state_reg <= ST_ANGLE;
                ST_ANGLE:
                begin
                    angle_reg <= angle_sat;
                    state_reg <= ST_ERR;
                end
                ST_ERR:       state_reg <= ST_BIAS_MUL;
                ST_BIAS_FIN:
                begin
                    bias_reg  <= bias_sat;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    // Wait until the output register is free.
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        pitch_reg     <= fail_reg ? 32'sd0 : angle_reg;
                        bias_out_reg  <= bias_reg;
                        valid_res_reg <= !fail_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers, driven by the sequencer state.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ax_reg <= accel_x;
                ay_reg <= accel_y;
                az_reg <= accel_z;
                gy_reg <= gyro_pitch;
            end
            ST_SQ:
            begin
                n_reg   <= {sq_sum[31:0], 16'b0};
                res_reg <= '0;
                bit_reg <= 47'(1) << 46;
            end
            ST_SQRT:
            begin
                if (sqrt_ge)
                begin
                    n_reg   <= n_reg - sqrt_trial[47:0];
                    res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            ST_CINIT:
            begin
                x_reg <= $signed({4'b0, res_reg[23:0]});
                y_reg <= {{4{ax_reg[15]}}, ax_reg, 8'b0};
                z_reg <= '0;
            end
            ST_CORDIC:
            begin
                if (y_reg > 28'sd0)
                begin
                    x_reg <= x_reg + y_shift;
                    y_reg <= y_reg - x_shift;
                    z_reg <= z_reg + atan_val;
                end
                else
                begin
                    x_reg <= x_reg - y_shift;
                    y_reg <= y_reg + x_shift;
                    z_reg <= z_reg - atan_val;
                end
            end
            ST_STEP_LOAD:
            begin
                mul_a_reg <= diff_mag;
                mul_b_reg <= {16'b0, gyro_step_gain_reg};
                neg_reg   <= diff[49];
                acc_reg   <= '0;
            end
            ST_STEP_MUL, ST_BLEND_MUL, ST_BIAS_MUL:
            begin
                if (cnt_reg < 6'd4)
                begin
                    prod_reg <= a_chunk * b_chunk;
                    psh_reg  <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                end
                if (cnt_reg != 6'd0)
                    acc_reg <= acc_reg + prod_aligned;
            end
            ST_STEP_FIN:
            begin
                mul_a_reg <= 50'(pred_err_mag);
                mul_b_reg <= {31'b0, kappa};
                neg_reg   <= pred_err[37];
                acc_reg   <= '0;
            end
            ST_BLEND_FIN:
                mix_reg <= mix;
            ST_ERR:
            begin
                mul_a_reg <= 50'(angle_err_mag);
                mul_b_reg <= bias_gain_reg;
                neg_reg   <= angle_err[32];
                acc_reg   <= '0;
            end
            default: ;
        endcase
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign pitch_angle   = pitch_reg;
    assign bias_estimate = bias_out_reg;
    assign valid_res     = valid_res_reg;

`ifndef SYNTHESIS
    // An accepted request keeps the input stalled on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted request");

    // The CORDIC counter never runs past the configured step count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORDIC) |-> (cnt_reg < 6'(CORDIC_STEPS)))
        else $error("CORDIC counter out of range");

    // A failed-read result carries a zero angle and the held bias.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && !valid_res) |->
            (pitch_angle == 32'sd0 && bias_estimate == bias_reg))
        else $error("failed-read result malformed");

    // The multiplier counter never runs past four.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP_MUL || state_reg == ST_BLEND_MUL ||
         state_reg == ST_BIAS_MUL) |-> (cnt_reg <= 6'd4))
        else $error("multiplier counter out of range");
`endif

endmodule
